// File: sv/dwtc_pkg.sv
// ----------------------------------------------------------------------------
// Decayed word topic classifier package
// Shared widths, codes, state encoding and the exponential table builder.
// ----------------------------------------------------------------------------
package dwtc_pkg;

    // Default sizes of the vocabulary and of the class set.
    localparam int VOCAB_WORDS_DEF = 1024;
    localparam int MAX_CLASSES_DEF = 8;

    // Field widths.
    localparam int ACT_W   = 2;
    localparam int WORD_W  = 10;
    localparam int CLS_W   = 3;
    localparam int STAT_W  = 20;
    localparam int PROB_W  = 16;
    localparam int HIST_W  = 24;
    localparam int SCORE_W = 40;
    localparam int DECAY_W = 16;
    localparam int CCNT_W  = 4;
    localparam int VSIZE_W = 11;
    localparam int CFGI_W  = 2;

    // Port widths: tdata padded to whole bytes.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;

    // Register reset values.
    localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd58982;
    localparam logic [CCNT_W-1:0]  CCNT_RESET  = 4'd2;
    localparam logic [VSIZE_W-1:0] VSIZE_RESET = 11'd1024;

    // Configuration register indexes.
    localparam logic [CFGI_W-1:0] CFG_DECAY       = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_CLASS_COUNT = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_VOCAB_SIZE  = 2'd2;

    // History constants: 1.0 in Q5.19 and the saturation ceiling.
    localparam logic [HIST_W:0]   HIST_ONE = 25'd524288;
    localparam logic [HIST_W-1:0] HIST_MAX = 24'hFF_FFFF;

    // Exponential table: about exp(-k/64) in Q1.16, with 1.0 at entry zero.
    localparam int EXP_ROM_DEPTH = 1025;
    localparam int EXP_AW        = 11;
    localparam int EXP_W         = 17;
    localparam logic [32:0] EXP_STEP = 33'd4228380001;
    localparam int DIFF_W        = SCORE_W + 1;
    localparam logic [DIFF_W-1:0] DIFF_LIMIT = 41'd65536;

    // Item kinds carried on tuser.
    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD_PRIOR = 2'd0,
        ACT_LOAD_STAT  = 2'd1,
        ACT_WORD       = 2'd2,
        ACT_CLEAR      = 2'd3
    } action_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECAY,
        ST_DECAY_DRAIN,
        ST_SCORE,
        ST_SCORE_DRAIN,
        ST_SM_DIFF,
        ST_SM_ROM,
        ST_SM_WGT,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

    typedef logic [EXP_W-1:0] exp_rom_t [EXP_ROM_DEPTH];

    // Builds the exponential table by repeated fixed-point multiplication.
    function automatic exp_rom_t build_exp_rom();
        exp_rom_t    rom;
        logic [64:0] acc;
        acc = 65'd1 << 32;
        for (int k = 0; k < EXP_ROM_DEPTH; k++) begin
            rom[k] = EXP_W'((acc + 65'd32768) >> 16);
            acc    = (acc * 65'(EXP_STEP) + (65'd1 << 31)) >> 32;
        end
        return rom;
    endfunction

endpackage

// File: sv/decayed_word_topic_classifier_unit.sv
// Load items are taken in idle without leaving it; configuration writes are always accepted.
// A known word decays the history, scores each class, then forms softmax weights and divides
// per class, and output stalls can hold it; one shared multiplier walks the history memory.
// Unknown words are dropped; a history reset item sweeps the history memory to zero.
// After aresetn the history memory is swept to zero with s_tready low.
// ----------------------------------------------------------------------------
// Decayed word topic classifier
// Naive Bayes topic scoring over a decayed word history, with softmax output.
// ----------------------------------------------------------------------------
module decayed_word_topic_classifier_unit #(
    parameter int VOCAB_WORDS = dwtc_pkg::VOCAB_WORDS_DEF,
    parameter int MAX_CLASSES = dwtc_pkg::MAX_CLASSES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // word_index, class_index, stat_value (lowest bit up), zero padded
    input  logic [dwtc_pkg::S_TDATA_W-1:0] s_tdata,
    // action
    input  logic [dwtc_pkg::ACT_W-1:0]     s_tuser,
    // Result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // class_id, probability, best_class (lowest bit up), zero padded
    output logic [dwtc_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast,
    // Configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dwtc_pkg::CFGI_W-1:0]    cfg_index,
    input  logic [dwtc_pkg::DECAY_W-1:0]   cfg_data
);
    import dwtc_pkg::*;

    localparam int VW     = (VOCAB_WORDS > 1) ? $clog2(VOCAB_WORDS) : 1;
    localparam int CW     = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int NV_W   = VW + 1;
    localparam int CN_W   = CW + 1;
    localparam int LLA_W  = VW + CW;
    localparam int LL_DEPTH = VOCAB_WORDS << CW;
    localparam int PROD_W = HIST_W + STAT_W + 2;
    localparam int ACC_W  = HIST_W + STAT_W + 1 + VW;
    localparam int SUM_W  = EXP_W + CW;
    localparam logic signed [71:0] SCORE_HI = 72'sh7F_FFFF_FFFF;
    localparam logic signed [71:0] SCORE_LO = -SCORE_HI - 72'sd1;
    localparam exp_rom_t EXP_ROM = build_exp_rom();

    // Configuration registers.
    logic [DECAY_W-1:0] decay_reg;
    logic [CCNT_W-1:0]  ccnt_reg;
    logic [VSIZE_W-1:0] vsize_reg;

    // Sequencer and datapath registers.
    state_t                     state_reg, state_next;
    logic [NV_W-1:0]            idx_reg, idx_next;
    logic [CW-1:0]              cls_reg, cls_next;
    logic [VW-1:0]              word_reg;
    logic                       p1_vld_reg, p2_vld_reg;
    logic [VW-1:0]              p1_idx_reg, p2_idx_reg;
    logic [HIST_W-1:0]          hist_q;
    logic signed [STAT_W-1:0]   ll_q;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [STAT_W-1:0]   prior_reg [MAX_CLASSES];
    logic signed [SCORE_W-1:0]  score_reg [MAX_CLASSES];
    logic [EXP_W-1:0]           weight_reg [MAX_CLASSES];
    logic signed [SCORE_W-1:0]  best_score_reg, best_score_next;
    logic [CW-1:0]              best_reg, best_next;
    logic                       far_reg, far_next;
    logic [WORD_W-1:0]          k_reg, k_next;
    logic [5:0]                 r_reg, r_next;
    logic [EXP_W-1:0]           rom_hi_q, rom_lo_q;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic [M_TDATA_W-1:0]       out_data_reg, out_data_next;
    logic                       out_last_reg, out_last_next;

    // Memories.
    logic [HIST_W-1:0]        hist_mem [VOCAB_WORDS];
    logic signed [STAT_W-1:0] ll_mem [LL_DEPTH];

    // Input unpacking.
    logic [WORD_W-1:0]        s_word;
    logic [CLS_W-1:0]         s_cls;
    logic signed [STAT_W-1:0] s_stat;
    action_t                  s_act;
    logic [16:0]              s_word_ext;
    logic [6:0]               s_cls_ext;
    logic [VW-1:0]            s_word_addr;
    logic [CW-1:0]            s_cls_addr;
    logic                     s_acc;

    // Decoded controls.
    logic [NV_W-1:0]          nv;
    logic [CN_W-1:0]          nc;
    logic                     last_cls;
    logic                     last_idx;
    logic                     pipe_empty;
    logic                     decay_mode;
    logic                     issue;
    logic                     word_known;
    logic                     prior_we, ll_we, score_we, weight_we;
    logic                     hist_we;
    logic [VW-1:0]            hist_wa;
    logic [HIST_W-1:0]        hist_wd;
    logic signed [HIST_W:0]   mul_a;
    logic signed [STAT_W:0]   mul_b;
    logic [HIST_W-1:0]        decayed;
    logic [HIST_W:0]          bumped;
    logic signed [ACC_W-1:0]  prior_init;
    logic [CW-1:0]            cls_inc;
    logic signed [71:0]       acc_floor;
    logic signed [SCORE_W-1:0] score_new;
    logic signed [DIFF_W-1:0] diff;
    logic [EXP_W-1:0]         rom_gap;
    logic [EXP_W+5:0]         rom_scaled;
    logic [EXP_W-1:0]         wgt;
    logic                     div_start;
    logic                     div_done;
    logic [EXP_W-1:0]         div_quot;
    logic [PROB_W-1:0]        prob;

    assign s_word      = s_tdata[WORD_W-1:0];
    assign s_cls       = s_tdata[WORD_W+CLS_W-1:WORD_W];
    assign s_stat      = signed'(s_tdata[WORD_W+CLS_W+STAT_W-1:WORD_W+CLS_W]);
    assign s_act       = action_t'(s_tuser);
    assign s_word_ext  = 17'(s_word);
    assign s_cls_ext   = 7'(s_cls);
    assign s_word_addr = s_word_ext[VW-1:0];
    assign s_cls_addr  = s_cls_ext[CW-1:0];
    assign s_tready    = (state_reg == ST_IDLE);
    assign s_acc       = s_tvalid && s_tready;
    assign cfg_ready   = 1'b1;

    // Effective vocabulary size and class count.
    assign nv = (32'(vsize_reg) > VOCAB_WORDS) ? NV_W'(VOCAB_WORDS) : NV_W'(vsize_reg);
    always_comb begin
        if (ccnt_reg == '0) begin
            nc = CN_W'(1);
        end else if (32'(ccnt_reg) > MAX_CLASSES) begin
            nc = CN_W'(MAX_CLASSES);
        end else begin
            nc = CN_W'(ccnt_reg);
        end
    end

    assign word_known = 32'(s_word) < 32'(nv);
    assign last_cls   = ({1'b0, cls_reg} == nc - CN_W'(1));
    assign last_idx   = (idx_reg == nv - NV_W'(1));
    assign pipe_empty = !p1_vld_reg && !p2_vld_reg;
    assign decay_mode = (state_reg == ST_DECAY) || (state_reg == ST_DECAY_DRAIN);
    assign issue      = (state_reg == ST_DECAY) || (state_reg == ST_SCORE);

    // Load write enables.
    assign prior_we = s_acc && (s_act == ACT_LOAD_PRIOR) && (32'(s_cls) < MAX_CLASSES);
    assign ll_we    = s_acc && (s_act == ACT_LOAD_STAT) && (32'(s_cls) < MAX_CLASSES)
                      && (32'(s_word) < VOCAB_WORDS);

    // Shared multiplier operands: decay factor or log-likelihood against history.
    assign mul_a = signed'({1'b0, hist_q});
    assign mul_b = decay_mode ? signed'({5'b0, decay_reg}) : signed'({ll_q[STAT_W-1], ll_q});

    // Decay write-back, with the named word raised by one and saturated.
    assign decayed = prod_reg[HIST_W+15:16];
    assign bumped  = {1'b0, decayed} + HIST_ONE;
    always_comb begin
        hist_we = 1'b0;
        hist_wa = idx_reg[VW-1:0];
        hist_wd = '0;
        if (state_reg == ST_CLEAR) begin
            hist_we = 1'b1;
        end else if (decay_mode && p2_vld_reg) begin
            hist_we = 1'b1;
            hist_wa = p2_idx_reg;
            if (p2_idx_reg == word_reg) begin
                hist_wd = bumped[HIST_W] ? HIST_MAX : bumped[HIST_W-1:0];
            end else begin
                hist_wd = decayed;
            end
        end
    end

    // Score rounding: floor to Q.12 and saturate to forty bits.
    assign cls_inc    = cls_reg + CW'(1);
    assign prior_init = ACC_W'(prior_reg[last_cls ? cls_reg : cls_inc]) <<< 19;
    assign acc_floor  = 72'(acc_reg >>> 19);
    assign score_new  = (acc_floor > SCORE_HI) ? SCORE_W'(SCORE_HI) :
                        (acc_floor < SCORE_LO) ? SCORE_W'(SCORE_LO) : SCORE_W'(acc_floor);

    // Softmax weight by linear interpolation in the exponential table.
    assign diff       = DIFF_W'(best_score_reg) - DIFF_W'(score_reg[cls_reg]);
    assign rom_gap    = rom_hi_q - rom_lo_q;
    assign rom_scaled = (EXP_W+6)'(rom_gap) * (EXP_W+6)'(r_reg);
    assign wgt        = far_reg ? '0 : rom_hi_q - rom_scaled[EXP_W+5:6];
    assign prob       = (div_quot > EXP_W'(16'hFFFF)) ? 16'hFFFF : div_quot[PROB_W-1:0];

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (idx_reg == NV_W'(VOCAB_WORDS - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_acc) begin
                    if (s_act == ACT_CLEAR) begin
                        state_next = ST_CLEAR;
                    end else if (s_act == ACT_WORD && word_known) begin
                        state_next = ST_DECAY;
                    end
                end
            end
            ST_DECAY: begin
                if (last_idx) state_next = ST_DECAY_DRAIN;
            end
            ST_DECAY_DRAIN: begin
                if (pipe_empty) state_next = ST_SCORE;
            end
            ST_SCORE: begin
                if (last_idx) state_next = ST_SCORE_DRAIN;
            end
            ST_SCORE_DRAIN: begin
                if (pipe_empty) state_next = last_cls ? ST_SM_DIFF : ST_SCORE;
            end
            ST_SM_DIFF:   state_next = ST_SM_ROM;
            ST_SM_ROM:    state_next = ST_SM_WGT;
            ST_SM_WGT:    state_next = last_cls ? ST_DIV_START : ST_SM_DIFF;
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_done) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) state_next = last_cls ? ST_IDLE : ST_DIV_START;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath controls per state.
    always_comb begin
        idx_next        = idx_reg;
        cls_next        = cls_reg;
        acc_next        = acc_reg;
        best_next       = best_reg;
        best_score_next = best_score_reg;
        far_next        = far_reg;
        k_next          = k_reg;
        r_next          = r_reg;
        sum_next        = sum_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        score_we        = 1'b0;
        weight_we       = 1'b0;
        div_start       = 1'b0;
        if (p2_vld_reg && !decay_mode) begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
        case (state_reg)
            ST_CLEAR: idx_next = idx_reg + NV_W'(1);
            ST_IDLE: idx_next = '0;
            ST_DECAY: idx_next = idx_reg + NV_W'(1);
            ST_DECAY_DRAIN: begin
                idx_next = '0;
                cls_next = '0;
                acc_next = ACC_W'(prior_reg[0]) <<< 19;
            end
            ST_SCORE: idx_next = idx_reg + NV_W'(1);
            ST_SCORE_DRAIN: begin
                if (pipe_empty) begin
                    score_we = 1'b1;
                    idx_next = '0;
                    if (cls_reg == '0 || best_score_reg < score_new) begin
                        best_next       = cls_reg;
                        best_score_next = score_new;
                    end
                    if (last_cls) begin
                        cls_next = '0;
                        sum_next = '0;
                    end else begin
                        cls_next = cls_inc;
                        acc_next = prior_init;
                    end
                end
            end
            ST_SM_DIFF: begin
                far_next = diff >= signed'(DIFF_LIMIT);
                k_next   = diff[15:6];
                r_next   = diff[5:0];
            end
            ST_SM_ROM: begin
            end
            ST_SM_WGT: begin
                weight_we = 1'b1;
                sum_next  = sum_reg + SUM_W'(wgt);
                cls_next  = last_cls ? '0 : cls_inc;
            end
            ST_DIV_START: div_start = 1'b1;
            ST_DIV_WAIT: begin
                if (div_done) begin
                    out_data_next = {(M_TDATA_W-2*CLS_W-PROB_W)'(0), CLS_W'(best_reg),
                                     prob, CLS_W'(cls_reg)};
                    out_last_next = last_cls;
                end
            end
            ST_OUT: begin
                if (m_tready && !last_cls) cls_next = cls_inc;
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            idx_reg    <= '0;
            cls_reg    <= '0;
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            decay_reg  <= DECAY_RESET;
            ccnt_reg   <= CCNT_RESET;
            vsize_reg  <= VSIZE_RESET;
        end else begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            cls_reg    <= cls_next;
            p1_vld_reg <= issue;
            p2_vld_reg <= p1_vld_reg;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DECAY:       decay_reg <= cfg_data;
                    CFG_CLASS_COUNT: ccnt_reg  <= cfg_data[CCNT_W-1:0];
                    CFG_VOCAB_SIZE:  vsize_reg <= cfg_data[VSIZE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_acc) word_reg <= s_word_addr;
        p1_idx_reg     <= idx_reg[VW-1:0];
        p2_idx_reg     <= p1_idx_reg;
        prod_reg       <= PROD_W'(mul_a * mul_b);
        acc_reg        <= acc_next;
        best_reg       <= best_next;
        best_score_reg <= best_score_next;
        far_reg        <= far_next;
        k_reg          <= k_next;
        r_reg          <= r_next;
        sum_reg        <= sum_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
        if (prior_we) prior_reg[s_cls_addr] <= s_stat;
        if (score_we) score_reg[cls_reg] <= score_new;
        if (weight_we) weight_reg[cls_reg] <= wgt;
    end

    // History memory: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (hist_we) hist_mem[hist_wa] <= hist_wd;
        hist_q <= hist_mem[idx_reg[VW-1:0]];
    end

    // Log-likelihood memory, addressed by word then class.
    always_ff @(posedge aclk) begin
        if (ll_we) ll_mem[LLA_W'({s_word_addr, s_cls_addr})] <= s_stat;
        ll_q <= ll_mem[LLA_W'({idx_reg[VW-1:0], cls_reg})];
    end

    // Exponential table, read at two neighbouring entries.
    always_ff @(posedge aclk) begin
        rom_hi_q <= EXP_ROM[EXP_AW'(k_reg)];
        rom_lo_q <= EXP_ROM[EXP_AW'(k_reg) + EXP_AW'(1)];
    end

    dwtc_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .weight  (weight_reg[cls_reg]),
        .sum     (sum_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // Input is never taken while a result transaction is pending.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("input ready while a result is pending");

    // The last result of a run returns the block to idle.
    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("block not idle after last result");

    // The best class always carries a nonzero probability.
    a_best_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2:0] == m_tdata[21:19]) |-> (m_tdata[18:3] != 16'd0))
        else $error("best class reported with zero probability");

endmodule

// File: sv/dwtc_div.sv
// ----------------------------------------------------------------------------
// Probability divider
// Restoring divider that forms floor(weight * 65536 / sum), one bit a cycle.
// ----------------------------------------------------------------------------
module dwtc_div #(
    parameter int SUM_W = 20
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [dwtc_pkg::EXP_W-1:0] weight,
    input  logic [SUM_W-1:0]         sum,
    output logic                     done,
    output logic [dwtc_pkg::EXP_W-1:0] quot
);
    import dwtc_pkg::*;

    localparam int CNT_W = $clog2(EXP_W + 1);

    logic [SUM_W-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0] div_reg, div_next;
    logic [EXP_W-1:0] low_reg, low_next;
    logic [EXP_W-1:0] quot_reg, quot_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [SUM_W:0]   rem_shift;
    logic [SUM_W:0]   rem_sub;
    logic             fits;

    // One trial subtraction per cycle.
    assign rem_shift = {rem_reg, low_reg[EXP_W-1]};
    assign rem_sub   = rem_shift - {1'b0, div_reg};
    assign fits      = rem_shift >= {1'b0, div_reg};

    // The upper dividend bits (weight >> 1) are below the divisor, so only the
    // low seventeen bits of weight * 65536 need a step each.
    always_comb begin
        rem_next  = rem_reg;
        div_next  = div_reg;
        low_next  = low_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = SUM_W'(weight >> 1);
            div_next  = sum;
            low_next  = {weight[0], (EXP_W-1)'(0)};
            quot_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? rem_sub[SUM_W-1:0] : rem_shift[SUM_W-1:0];
            quot_next = {quot_reg[EXP_W-2:0], fits};
            low_next  = {low_reg[EXP_W-2:0], 1'b0};
            cnt_next  = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(EXP_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule
